>>> sv/ds_twr_distance_calc_defines.svh
// Assertion macros shared by the checker of the ranging block.
`ifndef DS_TWR_DISTANCE_CALC_DEFINES_SVH
`define DS_TWR_DISTANCE_CALC_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define DSTWR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define DSTWR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dstwr_pkg.sv
package dstwr_pkg;

    localparam int LOCAL_TS_BITS_DEF = 40;
    localparam int TAG_TS_BITS_DEF   = 32;
    localparam int LOCAL_FIELD_W     = 40;
    localparam int TAG_FIELD_W       = 32;

    localparam int SCALE_W   = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307386;
    localparam int FRAC_BITS = 16;
    localparam int CHUNK_W   = 24;
    localparam int DIST_W    = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    typedef enum logic {
        REG_MM_PER_TICK = 1'b0
    } t_reg_idx;

    // Control flags that ride along with each word in the pipeline.
    typedef struct packed {
        logic valid;
        logic zden;
        logic neg;
        logic ovf;
    } t_side;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> sv/ds_twr_distance_calc.sv
// Double-sided two-way ranging distance unit.
// Input channel: one word per ranging exchange, six timestamps, taken when
// i_valid is high and o_stall is low. Output channel: one word per input word,
// in the same order, taken when o_valid is high and i_stall is low.
// The distance is the signed time of flight scaled by mm_per_tick_q16, which
// is written over the APB port at byte address 0 and is read back there.
// A new word can enter every cycle while o_stall is low. The
// register pipeline has three stages for the interval products,
// three for magnitude and scaling, one setup stage, one stage per
// quotient bit of the 32-step restoring divider and an output stage.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_stall goes high in the same cycle; nothing is dropped or sent
// twice. A zero interval sum gives distance 0 with o_zero_denominator set.
// Reset empties the pipeline and loads the scale register with 307386.
module ds_twr_distance_calc #(
    parameter int LOCAL_TS_BITS = dstwr_pkg::LOCAL_TS_BITS_DEF,
    parameter int TAG_TS_BITS   = dstwr_pkg::TAG_TS_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dstwr_pkg::LOCAL_FIELD_W-1:0] i_local_poll_rx_time,
    input  logic [dstwr_pkg::LOCAL_FIELD_W-1:0] i_local_resp_tx_time,
    input  logic [dstwr_pkg::LOCAL_FIELD_W-1:0] i_local_final_rx_time,
    input  logic [dstwr_pkg::TAG_FIELD_W-1:0]   i_tag_poll_tx_time,
    input  logic [dstwr_pkg::TAG_FIELD_W-1:0]   i_tag_resp_rx_time,
    input  logic [dstwr_pkg::TAG_FIELD_W-1:0]   i_tag_final_tx_time,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dstwr_pkg::DIST_W-1:0] o_range_mm,
    output logic                                o_zero_denominator,
    output logic                                o_saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dstwr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dstwr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dstwr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import dstwr_pkg::*;

    localparam int PW  = LOCAL_TS_BITS + TAG_TS_BITS;
    localparam int DNW = max_int(LOCAL_TS_BITS, TAG_TS_BITS) + 2;
    localparam int PRW = PW + SCALE_W;

    logic [SCALE_W-1:0] r_mm_per_tick;
    logic [SCALE_W-1:0] n_mm_per_tick;
    logic               n_cfg_wr;
    t_reg_idx           n_reg_idx;

    logic en;

    t_side            mul_side;
    logic [PW-1:0]    mul_p1, mul_p2;
    logic [DNW-1:0]   mul_den;
    t_side            scl_side;
    logic [PRW-1:0]   scl_prod;
    logic [DNW-1:0]   scl_den;
    t_side            div_side;
    logic [DIST_W-1:0] div_dist;
    logic             div_sat;

    // Everything moves together unless a finished word is held back.
    assign en      = !(div_side.valid && i_stall);
    assign o_stall = !en;

    // Configuration register.
    always_comb begin
        n_reg_idx     = t_reg_idx'(paddr[APB_ADDR_W-1]);
        n_cfg_wr      = psel && penable && pwrite && (n_reg_idx == REG_MM_PER_TICK);
        n_mm_per_tick = n_cfg_wr ? pwdata[SCALE_W-1:0] : r_mm_per_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_per_tick <= SCALE_RESET;
        end else begin
            r_mm_per_tick <= n_mm_per_tick;
        end
    end

    always_comb begin
        case (n_reg_idx)
            REG_MM_PER_TICK: prdata = APB_DATA_W'(r_mm_per_tick);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    dstwr_prod #(
        .LOCAL_TS_BITS (LOCAL_TS_BITS),
        .TAG_TS_BITS   (TAG_TS_BITS)
    ) u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_lpoll  (LOCAL_TS_BITS'(i_local_poll_rx_time)),
        .i_lresp  (LOCAL_TS_BITS'(i_local_resp_tx_time)),
        .i_lfinal (LOCAL_TS_BITS'(i_local_final_rx_time)),
        .i_tpoll  (TAG_TS_BITS'(i_tag_poll_tx_time)),
        .i_tresp  (TAG_TS_BITS'(i_tag_resp_rx_time)),
        .i_tfinal (TAG_TS_BITS'(i_tag_final_tx_time)),
        .o_side   (mul_side),
        .o_p1     (mul_p1),
        .o_p2     (mul_p2),
        .o_den    (mul_den)
    );

    dstwr_scale #(
        .PW  (PW),
        .DNW (DNW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (mul_side),
        .i_p1    (mul_p1),
        .i_p2    (mul_p2),
        .i_den   (mul_den),
        .i_scale (r_mm_per_tick),
        .o_side  (scl_side),
        .o_prod  (scl_prod),
        .o_den   (scl_den)
    );

    dstwr_div #(
        .PRW (PRW),
        .DNW (DNW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (scl_side),
        .i_prod  (scl_prod),
        .i_den   (scl_den),
        .o_side  (div_side),
        .o_dist  (div_dist),
        .o_sat   (div_sat)
    );

    assign o_valid            = div_side.valid;
    assign o_range_mm         = div_dist;
    assign o_zero_denominator = div_side.zden;
    assign o_saturated        = div_sat;

endmodule

>>> sv/dstwr_prod.sv
module dstwr_prod #(
    parameter int LOCAL_TS_BITS = dstwr_pkg::LOCAL_TS_BITS_DEF,
    parameter int TAG_TS_BITS   = dstwr_pkg::TAG_TS_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [LOCAL_TS_BITS-1:0]       i_lpoll,
    input  logic [LOCAL_TS_BITS-1:0]       i_lresp,
    input  logic [LOCAL_TS_BITS-1:0]       i_lfinal,
    input  logic [TAG_TS_BITS-1:0]         i_tpoll,
    input  logic [TAG_TS_BITS-1:0]         i_tresp,
    input  logic [TAG_TS_BITS-1:0]         i_tfinal,
    output dstwr_pkg::t_side               o_side,
    output logic [LOCAL_TS_BITS+TAG_TS_BITS-1:0] o_p1,
    output logic [LOCAL_TS_BITS+TAG_TS_BITS-1:0] o_p2,
    output logic [dstwr_pkg::max_int(LOCAL_TS_BITS, TAG_TS_BITS)+1:0] o_den
);
    import dstwr_pkg::*;

    localparam int PW   = LOCAL_TS_BITS + TAG_TS_BITS;
    localparam int MW   = max_int(LOCAL_TS_BITS, TAG_TS_BITS);
    localparam int H    = (MW + 1) / 2;
    localparam int PADW = 2 * H;
    localparam int SUMW = 2 * PADW;
    localparam int DNW  = MW + 2;

    // Stage A: the four intervals, each modulo its timestamp width.
    t_side                    r_a_side;
    logic [TAG_TS_BITS-1:0]   r_round1;
    logic [TAG_TS_BITS-1:0]   r_reply1;
    logic [LOCAL_TS_BITS-1:0] r_round2;
    logic [LOCAL_TS_BITS-1:0] r_reply2;

    // Stage B: half-width partial products of both products.
    t_side            r_b_side;
    logic [PADW-1:0]  r_pp1 [0:3];
    logic [PADW-1:0]  r_pp2 [0:3];
    logic [DNW-1:0]   r_b_den;

    // Stage C: the two full products.
    t_side            r_c_side;
    logic [PW-1:0]    r_p1;
    logic [PW-1:0]    r_p2;
    logic [DNW-1:0]   r_c_den;

    t_side            n_a_side;
    t_side            n_b_side;
    logic [PADW-1:0]  n_a1, n_b1, n_a2, n_b2;
    logic [PADW-1:0]  n_pp1 [0:3];
    logic [PADW-1:0]  n_pp2 [0:3];
    logic [DNW-1:0]   n_den;
    logic [SUMW-1:0]  n_s1, n_s2;

    always_comb begin
        n_a1 = PADW'(r_round1);
        n_b1 = PADW'(r_round2);
        n_a2 = PADW'(r_reply1);
        n_b2 = PADW'(r_reply2);
        n_pp1[0] = PADW'(n_a1[H-1:0])    * PADW'(n_b1[H-1:0]);
        n_pp1[1] = PADW'(n_a1[H-1:0])    * PADW'(n_b1[PADW-1:H]);
        n_pp1[2] = PADW'(n_a1[PADW-1:H]) * PADW'(n_b1[H-1:0]);
        n_pp1[3] = PADW'(n_a1[PADW-1:H]) * PADW'(n_b1[PADW-1:H]);
        n_pp2[0] = PADW'(n_a2[H-1:0])    * PADW'(n_b2[H-1:0]);
        n_pp2[1] = PADW'(n_a2[H-1:0])    * PADW'(n_b2[PADW-1:H]);
        n_pp2[2] = PADW'(n_a2[PADW-1:H]) * PADW'(n_b2[H-1:0]);
        n_pp2[3] = PADW'(n_a2[PADW-1:H]) * PADW'(n_b2[PADW-1:H]);
        n_den = DNW'(r_round1) + DNW'(r_reply1) + DNW'(r_round2) + DNW'(r_reply2);
        n_a_side       = '0;
        n_a_side.valid = i_valid;
        n_b_side       = r_a_side;
        n_b_side.zden  = (n_den == '0);
    end

    always_comb begin
        n_s1 = SUMW'(r_pp1[0])
             + ((SUMW'(r_pp1[1]) + SUMW'(r_pp1[2])) << H)
             + (SUMW'(r_pp1[3]) << PADW);
        n_s2 = SUMW'(r_pp2[0])
             + ((SUMW'(r_pp2[1]) + SUMW'(r_pp2[2])) << H)
             + (SUMW'(r_pp2[3]) << PADW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
        end else if (i_en) begin
            r_a_side <= n_a_side;
            r_b_side <= n_b_side;
            r_c_side <= r_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_round1 <= i_tresp - i_tpoll;
            r_reply1 <= i_tfinal - i_tresp;
            r_round2 <= i_lfinal - i_lresp;
            r_reply2 <= i_lresp - i_lpoll;
            for (int k = 0; k < 4; k++) begin
                r_pp1[k] <= n_pp1[k];
                r_pp2[k] <= n_pp2[k];
            end
            r_b_den <= n_den;
            r_p1    <= PW'(n_s1);
            r_p2    <= PW'(n_s2);
            r_c_den <= r_b_den;
        end
    end

    assign o_side = r_c_side;
    assign o_p1   = r_p1;
    assign o_p2   = r_p2;
    assign o_den  = r_c_den;

endmodule

>>> sv/dstwr_scale.sv
module dstwr_scale #(
    parameter int PW  = dstwr_pkg::LOCAL_TS_BITS_DEF + dstwr_pkg::TAG_TS_BITS_DEF,
    parameter int DNW = dstwr_pkg::LOCAL_TS_BITS_DEF + 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  dstwr_pkg::t_side                     i_side,
    input  logic [PW-1:0]                        i_p1,
    input  logic [PW-1:0]                        i_p2,
    input  logic [DNW-1:0]                       i_den,
    input  logic [dstwr_pkg::SCALE_W-1:0]        i_scale,
    output dstwr_pkg::t_side                     o_side,
    output logic [PW+dstwr_pkg::SCALE_W-1:0]     o_prod,
    output logic [DNW-1:0]                       o_den
);
    import dstwr_pkg::*;

    localparam int NCH  = (PW + CHUNK_W - 1) / CHUNK_W;
    localparam int MPW  = NCH * CHUNK_W;
    localparam int CPW  = CHUNK_W + SCALE_W;
    localparam int SUMW = MPW + SCALE_W;
    localparam int PRW  = PW + SCALE_W;

    // Stage D: magnitude of the numerator and its sign.
    t_side           r_d_side;
    logic [PW-1:0]   r_mag;
    logic [DNW-1:0]  r_d_den;

    // Stage E: chunk-by-scale partial products.
    t_side           r_e_side;
    logic [CPW-1:0]  r_cp [0:NCH-1];
    logic [DNW-1:0]  r_e_den;

    // Stage F: scaled numerator.
    t_side           r_f_side;
    logic [PRW-1:0]  r_prod;
    logic [DNW-1:0]  r_f_den;

    t_side           n_d_side;
    logic            n_ge;
    logic [PW-1:0]   n_mag;
    logic [MPW-1:0]  n_mag_pad;
    logic [CPW-1:0]  n_cp [0:NCH-1];
    logic [SUMW-1:0] n_acc;

    always_comb begin
        n_ge  = (i_p1 >= i_p2);
        n_mag = n_ge ? (i_p1 - i_p2) : (i_p2 - i_p1);
        n_d_side     = i_side;
        n_d_side.neg = !n_ge;
    end

    always_comb begin
        n_mag_pad = MPW'(r_mag);
        for (int c = 0; c < NCH; c++) begin
            n_cp[c] = CPW'(n_mag_pad[c*CHUNK_W +: CHUNK_W]) * CPW'(i_scale);
        end
    end

    always_comb begin
        n_acc = '0;
        for (int c = 0; c < NCH; c++) begin
            n_acc = n_acc + (SUMW'(r_cp[c]) << (c * CHUNK_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
            r_e_side <= '0;
            r_f_side <= '0;
        end else if (i_en) begin
            r_d_side <= n_d_side;
            r_e_side <= r_d_side;
            r_f_side <= r_e_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= n_mag;
            r_d_den <= i_den;
            for (int c = 0; c < NCH; c++) begin
                r_cp[c] <= n_cp[c];
            end
            r_e_den <= r_d_den;
            r_prod  <= PRW'(n_acc);
            r_f_den <= r_e_den;
        end
    end

    assign o_side = r_f_side;
    assign o_prod = r_prod;
    assign o_den  = r_f_den;

endmodule

>>> sv/dstwr_div.sv
module dstwr_div #(
    parameter int PRW = dstwr_pkg::LOCAL_TS_BITS_DEF + dstwr_pkg::TAG_TS_BITS_DEF
                        + dstwr_pkg::SCALE_W,
    parameter int DNW = dstwr_pkg::LOCAL_TS_BITS_DEF + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  dstwr_pkg::t_side              i_side,
    input  logic [PRW-1:0]                i_prod,
    input  logic [DNW-1:0]                i_den,
    output dstwr_pkg::t_side              o_side,
    output logic [dstwr_pkg::DIST_W-1:0]  o_dist,
    output logic                          o_sat
);
    import dstwr_pkg::*;

    localparam int QB  = DIST_W;
    localparam int DVW = DNW + FRAC_BITS;
    localparam int HIW = PRW - QB;
    localparam int CW  = max_int(HIW, DVW);

    // Entry 0 is the setup stage, entry k+1 holds the word after quotient step k.
    t_side           r_side [0:QB];
    logic [DVW-1:0]  r_rem  [0:QB];
    logic [DVW-1:0]  r_dv   [0:QB];
    logic [QB-1:0]   r_w    [0:QB];

    t_side             r_o_side;
    logic [DIST_W-1:0] r_dist;
    logic              r_sat;

    t_side           n_side0;
    logic [DVW-1:0]  n_dv0;
    logic [HIW-1:0]  n_hi0;
    logic            n_ovf0;
    logic [DVW:0]    n_t   [0:QB-1];
    logic            n_ge  [0:QB-1];
    logic [DVW-1:0]  n_rem [0:QB-1];
    logic [QB-1:0]   n_w   [0:QB-1];

    logic [QB-1:0]     n_q;
    logic [DIST_W-1:0] n_dist;
    logic              n_sat;

    // The whole divisor is D * 2^16. If the high part of the dividend already
    // reaches it, the quotient needs more than 32 bits and the result clamps.
    always_comb begin
        n_dv0  = {i_den, {FRAC_BITS{1'b0}}};
        n_hi0  = i_prod[PRW-1:QB];
        n_ovf0 = (CW'(n_hi0) >= CW'(n_dv0));
        n_side0     = i_side;
        n_side0.ovf = n_ovf0;
    end

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_t[k]   = {r_rem[k], r_w[k][QB-1]};
            n_ge[k]  = (n_t[k] >= {1'b0, r_dv[k]});
            n_rem[k] = n_ge[k] ? DVW'(n_t[k] - {1'b0, r_dv[k]}) : DVW'(n_t[k]);
            n_w[k]   = {r_w[k][QB-2:0], n_ge[k]};
        end
    end

    always_comb begin
        n_q = r_w[QB];
        if (r_side[QB].zden) begin
            n_dist = '0;
            n_sat  = 1'b0;
        end else if (r_side[QB].ovf) begin
            n_dist = r_side[QB].neg ? DIST_MIN : DIST_MAX;
            n_sat  = 1'b1;
        end else if (!r_side[QB].neg) begin
            n_sat  = (n_q > DIST_MAX);
            n_dist = n_sat ? DIST_MAX : n_q;
        end else begin
            n_sat  = (n_q > DIST_MIN);
            n_dist = n_sat ? DIST_MIN : (DIST_W'(0) - n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_side[k] <= '0;
            end
            r_o_side <= '0;
        end else if (i_en) begin
            r_side[0] <= n_side0;
            for (int k = 0; k < QB; k++) begin
                r_side[k+1] <= r_side[k];
            end
            r_o_side <= r_side[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DVW'(n_hi0);
            r_dv[0]  <= n_dv0;
            r_w[0]   <= i_prod[QB-1:0];
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_dv[k+1]  <= r_dv[k];
                r_w[k+1]   <= n_w[k];
            end
            r_dist <= n_dist;
            r_sat  <= n_sat;
        end
    end

    assign o_side = r_o_side;
    assign o_dist = r_dist;
    assign o_sat  = r_sat;

endmodule

>>> sv/dstwr_checker.sv
`include "ds_twr_distance_calc_defines.svh"

module dstwr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [dstwr_pkg::DIST_W-1:0] o_range_mm,
    input logic                                o_zero_denominator,
    input logic                                o_saturated
);
    import dstwr_pkg::*;

    `DSTWR_ASSERT_NOW(a_zden_gives_zero, o_valid && o_zero_denominator, o_range_mm == 32'sd0 && !o_saturated, "zero interval sum must give distance 0 without saturation")
    `DSTWR_ASSERT_NOW(a_sat_clamps, o_valid && o_saturated, o_range_mm == DIST_MAX || o_range_mm == DIST_MIN, "saturated word must carry a clamp value")
    `DSTWR_ASSERT_NOW(a_stall_backpressure, 1'b1, o_stall == (o_valid && i_stall), "input stall must follow a held output word")
    `DSTWR_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_range_mm) && $stable(o_saturated), "stalled output word changed")

endmodule

bind ds_twr_distance_calc dstwr_checker u_dstwr_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dstwr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_MM_PER_TICK = {REG_MM_PER_TICK, 2'b00};
    // Byte address of the first index past the register map; writes there are ignored.
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;
    localparam int                    MAX_REPORTS      = 40;

    typedef struct packed {
        logic [LOCAL_FIELD_W-1:0] lpoll;
        logic [LOCAL_FIELD_W-1:0] lresp;
        logic [LOCAL_FIELD_W-1:0] lfinal;
        logic [TAG_FIELD_W-1:0]   tpoll;
        logic [TAG_FIELD_W-1:0]   tresp;
        logic [TAG_FIELD_W-1:0]   tfinal;
    } t_exchange;

    typedef struct packed {
        logic signed [DIST_W-1:0] mm;
        logic                     zden;
        logic                     sat;
    } t_range_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [LOCAL_FIELD_W-1:0] i_local_poll_rx_time = '0;
    logic [LOCAL_FIELD_W-1:0] i_local_resp_tx_time = '0;
    logic [LOCAL_FIELD_W-1:0] i_local_final_rx_time = '0;
    logic [TAG_FIELD_W-1:0]   i_tag_poll_tx_time = '0;
    logic [TAG_FIELD_W-1:0]   i_tag_resp_rx_time = '0;
    logic [TAG_FIELD_W-1:0]   i_tag_final_tx_time = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DIST_W-1:0] o_range_mm;
    logic                     o_zero_denominator;
    logic                     o_saturated;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    t_exchange        exchanges_pending[$];
    t_range_result    ranges_expected[$];
    t_exchange        exchange_on_port;
    t_range_result    range_wanted;
    logic [SCALE_W-1:0] scale_q16 = SCALE_RESET;
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    int               n_errors = 0;

    ds_twr_distance_calc u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_local_poll_rx_time (i_local_poll_rx_time),
        .i_local_resp_tx_time (i_local_resp_tx_time),
        .i_local_final_rx_time(i_local_final_rx_time),
        .i_tag_poll_tx_time   (i_tag_poll_tx_time),
        .i_tag_resp_rx_time   (i_tag_resp_rx_time),
        .i_tag_final_tx_time  (i_tag_final_tx_time),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_range_mm           (o_range_mm),
        .o_zero_denominator   (o_zero_denominator),
        .o_saturated          (o_saturated),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Exact time of flight times scale, divided by the interval sum and 2^16.
    function automatic t_range_result predict_range(input t_exchange x,
                                                    input logic [SCALE_W-1:0] scale);
        logic [TAG_FIELD_W-1:0]   round1, reply1;
        logic [LOCAL_FIELD_W-1:0] round2, reply2;
        logic [47:0]              den;
        logic [127:0]             p1, p2, mag, prod, divisor, quo;
        logic                     neg;
        t_range_result            r;
        round1 = x.tresp - x.tpoll;
        reply1 = x.tfinal - x.tresp;
        round2 = x.lfinal - x.lresp;
        reply2 = x.lresp - x.lpoll;
        den = round1 + round2 + reply1 + reply2;
        r = '0;
        if (den == 0) begin
            r.zden = 1'b1;
            return r;
        end
        p1 = round1 * round2;
        p2 = reply1 * reply2;
        neg = p2 > p1;
        mag = neg ? p2 - p1 : p1 - p2;
        prod = mag * scale;
        divisor = den;
        divisor = divisor << FRAC_BITS;
        quo = prod / divisor;
        if (!neg) begin
            if (quo > DIST_MAX) begin
                r.sat = 1'b1;
                r.mm  = DIST_MAX;
            end else begin
                r.mm = quo[DIST_W-1:0];
            end
        end else begin
            if (quo > DIST_MIN) begin
                r.sat = 1'b1;
                r.mm  = DIST_MIN;
            end else begin
                r.mm = -quo[DIST_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_exchange from_intervals(input logic [LOCAL_FIELD_W-1:0] lbase,
                                                 input logic [TAG_FIELD_W-1:0] tbase,
                                                 input logic [TAG_FIELD_W-1:0] r1,
                                                 input logic [TAG_FIELD_W-1:0] y1,
                                                 input logic [LOCAL_FIELD_W-1:0] r2,
                                                 input logic [LOCAL_FIELD_W-1:0] y2);
        t_exchange x;
        x.tpoll  = tbase;
        x.tresp  = tbase + r1;
        x.tfinal = x.tresp + y1;
        x.lpoll  = lbase;
        x.lresp  = lbase + y2;
        x.lfinal = x.lresp + r2;
        return x;
    endfunction

    function automatic t_exchange rand_exchange();
        logic [LOCAL_FIELD_W-1:0] lbase, r2, y2;
        logic [TAG_FIELD_W-1:0]   tbase, r1, y1;
        int unsigned              kind, span, tof;
        t_exchange                x;
        lbase = LOCAL_FIELD_W'({$urandom(), $urandom()});
        tbase = $urandom();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // Each round trip is the other side's reply plus twice the flight time,
            // with a little clock drift on top.
            span = (kind % 3 == 0) ? 1000 : (kind % 3 == 1) ? 32'h000F_FFFF : 32'h3FFF_FFFF;
            tof = $urandom_range(0, 3000);
            y1 = $urandom_range(0, span);
            y2 = LOCAL_FIELD_W'($urandom_range(0, span));
            r1 = y2 + 2 * tof + $urandom_range(0, 64) - 32;
            r2 = y1 + 2 * tof + $urandom_range(0, 64) - 32;
            x = from_intervals(lbase, tbase, r1, y1, r2, y2);
        end else if (kind < 85) begin
            r1 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 255);
            y1 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 255);
            r2 = $urandom_range(0, 1) ? LOCAL_FIELD_W'({$urandom(), $urandom()})
                                      : LOCAL_FIELD_W'($urandom_range(0, 255));
            y2 = $urandom_range(0, 1) ? LOCAL_FIELD_W'({$urandom(), $urandom()})
                                      : LOCAL_FIELD_W'($urandom_range(0, 255));
            x = from_intervals(lbase, tbase, r1, y1, r2, y2);
        end else if (kind < 95) begin
            x.lpoll  = LOCAL_FIELD_W'({$urandom(), $urandom()});
            x.lresp  = LOCAL_FIELD_W'({$urandom(), $urandom()});
            x.lfinal = LOCAL_FIELD_W'({$urandom(), $urandom()});
            x.tpoll  = $urandom();
            x.tresp  = $urandom();
            x.tfinal = $urandom();
        end else begin
            x = from_intervals(lbase, tbase, '0, '0, '0, '0);
        end
        return x;
    endfunction

    // Sender: a new word is offered only once the current one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                ranges_expected.push_back(predict_range(exchange_on_port, scale_q16));
            end
            if (!i_valid || !o_stall) begin
                if (exchanges_pending.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    exchange_on_port = exchanges_pending.pop_front();
                    i_valid               <= 1'b1;
                    i_local_poll_rx_time  <= exchange_on_port.lpoll;
                    i_local_resp_tx_time  <= exchange_on_port.lresp;
                    i_local_final_rx_time <= exchange_on_port.lfinal;
                    i_tag_poll_tx_time    <= exchange_on_port.tpoll;
                    i_tag_resp_rx_time    <= exchange_on_port.tresp;
                    i_tag_final_tx_time   <= exchange_on_port.tfinal;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each taken word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (ranges_expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected word, distance %0d", $time, o_range_mm);
                end else begin
                    range_wanted = ranges_expected.pop_front();
                    if (o_range_mm !== range_wanted.mm) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: range_mm expected %0d actual %0d",
                                     $time, range_wanted.mm, o_range_mm);
                    end
                    if (o_zero_denominator !== range_wanted.zden) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: zero_denominator expected %0b actual %0b",
                                     $time, range_wanted.zden, o_zero_denominator);
                    end
                    if (o_saturated !== range_wanted.sat) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: saturated expected %0b actual %0b",
                                     $time, range_wanted.sat, o_saturated);
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_scale_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_MM_PER_TICK, '0, rd);
        if (rd !== APB_DATA_W'(scale_q16)) begin
            n_errors++;
            $display("%0t: mm_per_tick_q16 readback expected %0d actual %0d",
                     $time, scale_q16, rd);
        end
    endtask

    task automatic set_scale(input logic [APB_DATA_W-1:0] wdata);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_MM_PER_TICK, wdata, rd);
        scale_q16 = wdata[SCALE_W-1:0];
        check_scale_readback();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (exchanges_pending.size() != 0 || i_valid || ranges_expected.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
            exchanges_pending.push_back(rand_exchange());
        wait_drained();
    endtask

    initial begin
        t_exchange             x;
        logic [APB_DATA_W-1:0] rd;
        logic [LOCAL_FIELD_W-1:0] lb;
        logic [TAG_FIELD_W-1:0]   tb;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        check_scale_readback();

        snd_idle_pct = 31;
        rcv_idle_pct = 75;
        @(negedge i_clk);

        // Zero interval sums: all-zero, all-ones and repeated random stamps.
        exchanges_pending.push_back('0);
        exchanges_pending.push_back('1);
        lb = LOCAL_FIELD_W'({$urandom(), $urandom()});
        tb = $urandom();
        exchanges_pending.push_back(from_intervals(lb, tb, '0, '0, '0, '0));
        // Each field alone at its maximum.
        for (int f = 0; f < 6; f++) begin
            x = '0;
            case (f)
                0: x.lpoll  = '1;
                1: x.lresp  = '1;
                2: x.lfinal = '1;
                3: x.tpoll  = '1;
                4: x.tresp  = '1;
                default: x.tfinal = '1;
            endcase
            exchanges_pending.push_back(x);
        end
        // Tiny positive and negative flights show truncation toward zero.
        exchanges_pending.push_back(from_intervals('0, '0, 1, 0, 1, 0));
        exchanges_pending.push_back(from_intervals('0, '0, 0, 1, 0, 1));
        exchanges_pending.push_back(from_intervals('0, '0, 5, 0, 0, 0));
        // Too large and too small.
        exchanges_pending.push_back(from_intervals('0, '0, '1, '0, '1, '0));
        exchanges_pending.push_back(from_intervals('0, '0, '0, '1, '0, '1));
        // A plausible exchange whose stamps wrap around on both sides.
        exchanges_pending.push_back(from_intervals(40'hFF_FFFF_F000, 32'hFFFF_FF00,
                                                   101200, 100000, 101200, 100000));
        exchanges_pending.push_back(rand_exchange());
        exchanges_pending.push_back(rand_exchange());
        wait_drained();

        // At unit scale the quotient can land exactly on the int32 limits.
        set_scale(32'd65536);
        exchanges_pending.push_back(from_intervals('0, '0, 32'hC000_0000, '0,
                                                   40'h01_8000_0000, '0));
        exchanges_pending.push_back(from_intervals('0, '0, '0, 32'hC000_0000,
                                                   '0, 40'h01_8000_0000));
        exchanges_pending.push_back(from_intervals('0, '0, 32'hFFFF_FFFE, '0,
                                                   40'hFF_FFFF_FFFE, '0));
        exchanges_pending.push_back(from_intervals('0, '0, '0, 32'hFFFF_FFFE,
                                                   '0, 40'h00_FFFF_FFFE));
        wait_drained();

        // Upper bits of the write data are dropped; the unmapped address is ignored.
        set_scale(32'hFFFF_FFFF);
        apb_access(1'b1, ADDR_UNMAPPED, $urandom(), rd);
        check_scale_readback();
        run_random(400);

        snd_idle_pct = 75;
        rcv_idle_pct = 31;
        set_scale({8'($urandom_range(0, 255)), 24'd0});
        run_random(150);

        set_scale($urandom_range(0, 24'hFF_FFFF));
        run_random(200);
        run_random(200);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_scale(APB_DATA_W'(SCALE_RESET));
        run_random(400);

        set_scale(32'd1);
        run_random(300);

        repeat (45) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/dstwr_pkg.sv
sv/dstwr_prod.sv
sv/dstwr_scale.sv
sv/dstwr_div.sv
sv/ds_twr_distance_calc.sv
sv/dstwr_checker.sv
dv/testbench.sv
